// File: sv/case_fold_trie_lookup_defines.svh
// Assertion macros used by the case-fold lookup controller.
`ifndef CASE_FOLD_TRIE_LOOKUP_DEFINES_SVH
`define CASE_FOLD_TRIE_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CFTL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define CFTL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define CFTL_ASSERT(lbl, clk, rst_n, prop)
`define CFTL_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: sv/cftl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the case-fold lookup.
package cftl_pkg;

	localparam int TRIE_WORDS = 4096;
	localparam int SEQ_WORDS  = 4096;
	localparam int TRIE_AW    = $clog2(TRIE_WORDS);
	localparam int SEQ_AW     = $clog2(SEQ_WORDS);

	localparam logic [15:0] NO_RECORD = 16'hFFFF;
	localparam logic [20:0] MAX_POINT = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [1:0]  LAST_LEVEL = 2'd3;

	typedef enum logic [1:0] {
		OP_WR_PLANE0 = 2'd0,
		OP_WR_PLANE1 = 2'd1,
		OP_WR_SEQ    = 2'd2,
		OP_FOLD      = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_SEQ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       write_en;
		logic       query_start;
		logic       walk_issue;
		logic       hit_load;
		logic       seq_issue;
		logic       seq_capture;
		logic       out_load;
		logic [1:0] level;
		logic [1:0] seq_cnt;
		logic [1:0] cap_idx;
	} cmd_t;

	typedef struct packed {
		logic       is_query;
		logic       walk_start;
		logic       rec_none;
		logic [2:0] seq_len;
	} status_t;

endpackage

// File: sv/cftl_ctrl.sv
// Controller state machine that sequences table writes, trie walks and sequence copies.
`include "case_fold_trie_lookup_defines.svh"

module cftl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_stall,
	input  cftl_pkg::status_t status,
	output logic             in_stall,
	output logic             out_valid,
	output cftl_pkg::cmd_t   cmd
);
	import cftl_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	logic [1:0] level_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       in_accept;

	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept && status.is_query) begin
					state_nxt = status.walk_start ? S_WALK : S_DONE;
				end
			end
			S_WALK: begin
				if (status.rec_none) begin
					state_nxt = S_DONE;
				end else if (level_q == LAST_LEVEL) begin
					state_nxt = S_SEQ;
				end
			end
			S_SEQ: begin
				if (cnt_q == status.seq_len) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall        = (state_q != S_IDLE);
		cmd             = '0;
		cmd.level       = level_q;
		cmd.seq_cnt     = cnt_q[1:0];
		cmd.cap_idx     = 2'(cnt_q - 3'd1);
		case (state_q)
			S_IDLE: begin
				cmd.write_en    = in_valid && !status.is_query;
				cmd.query_start = in_valid && status.is_query;
			end
			S_WALK: begin
				cmd.walk_issue = !status.rec_none && (level_q != LAST_LEVEL);
				cmd.hit_load   = !status.rec_none && (level_q == LAST_LEVEL);
			end
			S_SEQ: begin
				cmd.seq_issue   = (cnt_q < status.seq_len);
				cmd.seq_capture = (cnt_q != 3'd0);
			end
			S_DONE: begin
				cmd.out_load = !out_valid_q || !out_stall;
			end
			default: begin
				cmd.out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= 2'd0;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.query_start) begin
				level_q <= 2'd0;
			end else if (cmd.walk_issue) begin
				level_q <= level_q + 2'd1;
			end
			if (cmd.hit_load) begin
				cnt_q <= 3'd0;
			end else if (state_q == S_SEQ && cnt_q != status.seq_len) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CFTL_ASSERT(a_query_leaves_idle, clk, arst_n,
		(in_accept && status.is_query |=> state_q == S_WALK || state_q == S_DONE))
	`CFTL_ASSERT(a_hit_starts_copy, clk, arst_n,
		(cmd.hit_load |=> state_q == S_SEQ && cnt_q == 3'd0))
	`CFTL_ASSERT_NEVER(a_copy_in_range, clk, arst_n,
		state_q == S_SEQ && (cnt_q > status.seq_len || status.seq_len == 3'd0))

endmodule

// File: sv/cftl_dp.sv
// Datapath with the two trie stores, the sequence store and the result registers.
module cftl_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        opcode,
	input  logic [11:0]       address,
	input  logic [15:0]       write_data,
	input  logic [20:0]       codepoint,
	input  cftl_pkg::cmd_t    cmd,
	output cftl_pkg::status_t status,
	output logic [2:0]        fold_length,
	output logic [20:0]       folded_0,
	output logic [20:0]       folded_1,
	output logic [20:0]       folded_2,
	output logic [20:0]       folded_3,
	output logic              nontrivial,
	output logic              invalid_point
);
	import cftl_pkg::*;

	logic [15:0] plane0_mem [TRIE_WORDS];
	logic [15:0] plane1_mem [TRIE_WORDS];
	logic [15:0] seq_mem [SEQ_WORDS];

	logic [15:0] p0_rd_q;
	logic [15:0] p1_rd_q;
	logic [15:0] seq_rd_q;
	logic        trie_oor_q;
	logic        seq_oor_q;
	logic        plane_q;
	logic [20:0] cp_q;
	logic [20:0] pts_q [4];
	logic [2:0]  len_q;
	logic [13:0] base_q;
	logic        hit_q;
	logic        inv_q;

	logic [2:0]  fold_length_q;
	logic [20:0] folded_q [4];
	logic        nontrivial_q;
	logic        invalid_point_q;

	logic        invalid;
	logic        trie_wr_ok;
	logic        seq_wr_ok;
	logic [3:0]  nib;
	logic [19:0] trie_idx;
	logic        trie_oor;
	logic        trie_rd_en;
	logic [15:0] rec_eff;
	logic [14:0] seq_idx;
	logic        seq_oor;

	assign invalid = (codepoint > MAX_POINT) ||
		(codepoint >= SURR_LO && codepoint <= SURR_HI);
	assign trie_wr_ok = 21'(address) < 21'(TRIE_WORDS);
	assign seq_wr_ok  = 15'(address) < 15'(SEQ_WORDS);

	always_comb begin
		case (cmd.level)
			2'd0:    nib = cp_q[11:8];
			2'd1:    nib = cp_q[7:4];
			2'd2:    nib = cp_q[3:0];
			default: nib = cp_q[15:12];
		endcase
	end

	assign rec_eff    = trie_oor_q ? NO_RECORD : (plane_q ? p1_rd_q : p0_rd_q);
	assign trie_idx   = cmd.query_start ? 20'(codepoint[15:12]) : {rec_eff, nib};
	assign trie_oor   = {1'b0, trie_idx} >= 21'(TRIE_WORDS);
	assign trie_rd_en = cmd.query_start || cmd.walk_issue;

	assign seq_idx = {1'b0, base_q} + 15'(cmd.seq_cnt);
	assign seq_oor = seq_idx >= 15'(SEQ_WORDS);

	always_comb begin
		status            = '0;
		status.is_query   = (opcode == OP_FOLD);
		status.walk_start = !invalid && (codepoint[20:17] == 4'd0);
		status.rec_none   = (rec_eff == NO_RECORD);
		status.seq_len    = len_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.write_en && opcode == OP_WR_PLANE0 && trie_wr_ok) begin
			plane0_mem[TRIE_AW'(address)] <= write_data;
		end
		if (trie_rd_en) begin
			p0_rd_q <= plane0_mem[trie_idx[TRIE_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_en && opcode == OP_WR_PLANE1 && trie_wr_ok) begin
			plane1_mem[TRIE_AW'(address)] <= write_data;
		end
		if (trie_rd_en) begin
			p1_rd_q <= plane1_mem[trie_idx[TRIE_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_en && opcode == OP_WR_SEQ && seq_wr_ok) begin
			seq_mem[SEQ_AW'(address)] <= write_data;
		end
		if (cmd.seq_issue) begin
			seq_rd_q <= seq_mem[seq_idx[SEQ_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trie_oor_q <= 1'b0;
			seq_oor_q  <= 1'b0;
		end else begin
			if (trie_rd_en) begin
				trie_oor_q <= trie_oor;
			end
			if (cmd.seq_issue) begin
				seq_oor_q <= seq_oor;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			cp_q     <= codepoint;
			plane_q  <= codepoint[16];
			pts_q[0] <= codepoint;
			pts_q[1] <= 21'd0;
			pts_q[2] <= 21'd0;
			pts_q[3] <= 21'd0;
			len_q    <= 3'd1;
			hit_q    <= 1'b0;
			inv_q    <= invalid;
		end
		if (cmd.hit_load) begin
			len_q  <= {1'b0, rec_eff[1:0]} + 3'd1;
			base_q <= rec_eff[15:2];
			hit_q  <= 1'b1;
		end
		if (cmd.seq_capture) begin
			pts_q[cmd.cap_idx] <= {4'd0, plane_q, seq_oor_q ? 16'd0 : seq_rd_q};
		end
		if (cmd.out_load) begin
			fold_length_q   <= len_q;
			folded_q[0]     <= pts_q[0];
			folded_q[1]     <= pts_q[1];
			folded_q[2]     <= pts_q[2];
			folded_q[3]     <= pts_q[3];
			nontrivial_q    <= hit_q && !(len_q == 3'd1 && pts_q[0] == cp_q);
			invalid_point_q <= inv_q;
		end
	end

	assign fold_length   = fold_length_q;
	assign folded_0      = folded_q[0];
	assign folded_1      = folded_q[1];
	assign folded_2      = folded_q[2];
	assign folded_3      = folded_q[3];
	assign nontrivial    = nontrivial_q;
	assign invalid_point = invalid_point_q;

endmodule

// File: sv/case_fold_trie_lookup.sv
// Case-fold lookup engine: a trie walk over loaded tables giving folded code point sequences.
//
// One input channel (in_valid/in_stall) carries a word with an opcode. Opcodes 0 to 2 write
// write_data at address into the plane-0 trie, the plane-1 trie or the sequence table; a
// write produces no output word. Opcode 3 folds codepoint and produces exactly one output
// word on the out_valid/out_stall channel.
// A query outside planes 0 and 1, or an invalid code point, skips the trie walk and goes
// straight to the output register. A plane 0 or 1 query makes up to four dependent reads
// of the trie memories, one per nibble, each with registered read data and the plane bit
// selecting which plane's data is used, then one read of the sequence memory per folded
// point. A miss at any trie level (0 to 3) ends the walk early. The next word is accepted
// in the cycle after the result enters the output register, so a new query is not taken
// while one is still in progress.
// The output register holds a result while out_stall is high; the engine finishes its
// current query and then waits, and input words are taken again once the result has
// moved into the output register.
// Reset clears the controller and the output valid flag; the table contents are undefined
// until written and must be loaded before queries read them.
module case_fold_trie_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [11:0] address,
	input  logic [15:0] write_data,
	input  logic [20:0] codepoint,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  fold_length,
	output logic [20:0] folded_0,
	output logic [20:0] folded_1,
	output logic [20:0] folded_2,
	output logic [20:0] folded_3,
	output logic        nontrivial,
	output logic        invalid_point
);
	import cftl_pkg::*;

	cmd_t    cmd;
	status_t status;

	cftl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (status),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	cftl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (opcode),
		.address       (address),
		.write_data    (write_data),
		.codepoint     (codepoint),
		.cmd           (cmd),
		.status        (status),
		.fold_length   (fold_length),
		.folded_0      (folded_0),
		.folded_1      (folded_1),
		.folded_2      (folded_2),
		.folded_3      (folded_3),
		.nontrivial    (nontrivial),
		.invalid_point (invalid_point)
	);

endmodule
